@@ design/chhc_pkg.sv @@
package chhc_pkg;

    // Field widths
    localparam int AXIS_W     = 16;
    localparam int REQ_W      = 2;
    localparam int HEADING_W  = 15;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    // Heading resolution and CORDIC length
    localparam int HEADING_FRAC_BITS = 6;
    localparam int CORDIC_STEPS      = 16;
    localparam int STEP_W            = $clog2(CORDIC_STEPS);

    // CORDIC datapath: 16-bit axes pre-scaled by 256, plus growth headroom
    localparam int PRESCALE_SH = 8;
    localparam int XY_W        = 28;
    localparam int ACC_W       = 32;
    localparam int ANG_FRAC    = 20;
    localparam int HEAD_SH     = ANG_FRAC - HEADING_FRAC_BITS;
    localparam int ATAN_IDX_W  = 5;
    localparam logic signed [ACC_W-1:0] FULL_ANG = ACC_W'(180 * (2 ** ANG_FRAC));

    // Divide by five via reciprocal multiply: exact for magnitudes below 2^18
    localparam int SUM_W        = 19;
    localparam int RECIP5_SH    = 21;
    localparam int RECIP5_W     = 19;
    localparam int PROD_W       = SUM_W + RECIP5_W;
    localparam int QMAG_W       = 17;
    localparam logic [RECIP5_W-1:0] RECIP5 = RECIP5_W'((2 ** RECIP5_SH + 4) / 5);

    // Extreme tracking slots: axis * 2 + (1 for min)
    localparam int NUM_AXES = 3;
    localparam int NUM_EXT  = 6;
    localparam int EXT_IDX_W = 3;
    localparam logic [EXT_IDX_W-1:0] EXT_LAST = EXT_IDX_W'(NUM_EXT - 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_MEASURE = 2'd0,
        REQ_CAL     = 2'd1,
        REQ_COMMIT  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CORRECT,
        S_RUN,
        S_DONE
    } t_state;

    // Tracking request into / result tag out of the divide unit
    typedef struct packed {
        logic                 valid;
        logic                 upd;
        logic [EXT_IDX_W-1:0] tag;
    } t_trk_req;

    // atan(2^-i) in 2^-20 degree, rounded to nearest
    function automatic logic signed [ACC_W-1:0] atan_of(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'sd47185920;
            5'd1:  v = 32'sd27855475;
            5'd2:  v = 32'sd14718068;
            5'd3:  v = 32'sd7471121;
            5'd4:  v = 32'sd3750058;
            5'd5:  v = 32'sd1876857;
            5'd6:  v = 32'sd938658;
            5'd7:  v = 32'sd469357;
            5'd8:  v = 32'sd234682;
            5'd9:  v = 32'sd117342;
            5'd10: v = 32'sd58671;
            5'd11: v = 32'sd29335;
            5'd12: v = 32'sd14668;
            5'd13: v = 32'sd7334;
            5'd14: v = 32'sd3667;
            5'd15: v = 32'sd1833;
            5'd16: v = 32'sd917;
            5'd17: v = 32'sd458;
            5'd18: v = 32'sd229;
            5'd19: v = 32'sd115;
            5'd20: v = 32'sd57;
            5'd21: v = 32'sd29;
            5'd22: v = 32'sd14;
            5'd23: v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    // (a + b) / 2 truncated toward zero
    function automatic logic signed [AXIS_W-1:0] mid_tz(
        input logic signed [AXIS_W-1:0] a,
        input logic signed [AXIS_W-1:0] b
    );
        logic signed [AXIS_W:0] s;
        logic signed [AXIS_W:0] t;
        s = (AXIS_W+1)'(a) + (AXIS_W+1)'(b);
        t = s + (AXIS_W+1)'({1'b0, s[AXIS_W]});
        return AXIS_W'(t >>> 1);
    endfunction

endpackage

@@ design/chhc_div5.sv @@
module chhc_div5 import chhc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_trk_req                 i_req,
    input  logic signed [SUM_W-1:0]  i_sum,
    output t_trk_req                 o_rsp,
    output logic signed [AXIS_W-1:0] o_quot
);

    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [PROD_W-1:0] prod;
    logic [QMAG_W-1:0] qmag;
    logic signed [QMAG_W-1:0] qs;

    // Magnitude times reciprocal, sign restored: truncation toward zero
    always_comb begin
        neg  = i_sum[SUM_W-1];
        mag  = neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        prod = PROD_W'(mag) * PROD_W'(RECIP5);
        qmag = prod[RECIP5_SH +: QMAG_W];
        qs   = neg ? -$signed(qmag) : $signed(qmag);
    end

    // Result register; only the valid flag is cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp.valid <= 1'b0;
        end else begin
            o_rsp.valid <= i_req.valid;
        end
        o_rsp.upd <= i_req.upd;
        o_rsp.tag <= i_req.tag;
        o_quot    <= AXIS_W'(qs);
    end

endmodule

@@ design/chhc_cordic.sv @@
module chhc_cordic import chhc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [AXIS_W-1:0] i_x,
    input  logic signed [AXIS_W-1:0] i_y,
    output logic                     o_done,
    output logic [HEADING_W-1:0]     o_heading
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic                    r_busy;
    logic                    r_fin;
    logic [STEP_W-1:0]       r_step;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [XY_W-1:0]  x0;
    logic signed [XY_W-1:0]  y0;
    logic signed [ACC_W-1:0] acc0;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [ACC_W-1:0] ang;
    logic signed [XY_W-1:0]  n_x;
    logic signed [XY_W-1:0]  n_y;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] fsum;
    logic signed [ACC_W-1:0] fclamp;

    // Pre-scale and fold into the right half plane
    always_comb begin
        x0   = XY_W'(i_x) <<< PRESCALE_SH;
        y0   = XY_W'(i_y) <<< PRESCALE_SH;
        acc0 = '0;
        if (i_x[AXIS_W-1]) begin
            acc0 = i_y[AXIS_W-1] ? -FULL_ANG : FULL_ANG;
            x0   = -x0;
            y0   = -y0;
        end
    end

    // One vectoring step: two shifters, two adders and the angle adder
    always_comb begin
        dx    = r_y >>> r_step;
        dy    = r_x >>> r_step;
        ang   = atan_of(ATAN_IDX_W'(r_step));
        n_x   = r_x;
        n_y   = r_y;
        n_acc = r_acc;
        if (r_y != '0) begin
            if (!r_y[XY_W-1]) begin
                n_x   = r_x + dx;
                n_y   = r_y - dy;
                n_acc = r_acc + ang;
            end else begin
                n_x   = r_x - dx;
                n_y   = r_y + dy;
                n_acc = r_acc - ang;
            end
        end
    end

    // Offset to 0..360 degrees and clamp
    always_comb begin
        fsum   = r_acc + FULL_ANG;
        fclamp = fsum;
        if (fsum < 0) begin
            fclamp = '0;
        end else if (fsum > (FULL_ANG <<< 1)) begin
            fclamp = FULL_ANG <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == LAST_STEP) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= x0;
            r_y    <= y0;
            r_acc  <= acc0;
            r_step <= '0;
        end else if (r_busy) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_step <= r_step + 1'b1;
        end
        if (r_fin) begin
            o_heading <= HEADING_W'(fclamp >>> HEAD_SH);
        end
    end

endmodule

@@ design/compass_heading_hard_iron_cal.sv @@
// Channel  | Dir | Signals                                | Fields (low bit up)
// ---------+-----+----------------------------------------+--------------------------------
// sample   | in  | s_axis_tvalid/tready/tdata/tuser       | tdata: raw_x, raw_y, raw_z
//          |     |                                        | tuser: req_type
// result   | out | m_axis_tvalid/tready/tdata             | tdata: corr_x, corr_y, corr_z,
//          |     |                                        |        heading, 1 pad bit
//
// A request runs from acceptance to result valid through the iterative CORDIC unit,
// which does one vectoring step per cycle.
// Calibration tracking runs on a shared divide-by-five unit in parallel with it.
// Reset (i_rst_n low, synchronous) clears offsets, the calibration flag and handshakes.
// A new request is taken while the previous result waits; a stalled result holds the
// next one back at the end of its run.
module compass_heading_hard_iron_cal import chhc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // raw_x, raw_y, raw_z
    input  logic [REQ_W-1:0]      s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // corr_x, corr_y, corr_z, heading, pad
);

    t_state r_state;
    t_state n_state;

    logic [REQ_W-1:0]         r_req;
    logic signed [AXIS_W-1:0] r_raw  [NUM_AXES];
    logic signed [AXIS_W-1:0] r_off  [NUM_AXES];
    logic signed [AXIS_W-1:0] r_corr [NUM_AXES];
    logic signed [AXIS_W-1:0] r_ext  [NUM_EXT];
    logic                     r_cal_started;
    logic                     r_trk_run;
    logic [EXT_IDX_W-1:0]     r_trk;
    logic [HEADING_W-1:0]     r_head;
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;

    logic                     in_fire;
    logic                     out_load;
    logic                     cordic_start;
    logic                     cordic_done;
    logic [HEADING_W-1:0]     cordic_heading;
    logic signed [AXIS_W-1:0] corr [NUM_AXES];
    logic signed [AXIS_W-1:0] trk_v;
    logic signed [AXIS_W-1:0] trk_m;
    logic signed [SUM_W-1:0]  trk_sum;
    t_trk_req                 trk_req;
    t_trk_req                 trk_rsp;
    logic signed [AXIS_W-1:0] trk_quot;

    // Request sequencer
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        cordic_start  = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_CORRECT;
                end
            end
            S_CORRECT: begin
                cordic_start = 1'b1;
                n_state      = S_RUN;
            end
            S_RUN: begin
                if (cordic_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if ((!r_out_valid || m_axis_tready) && !r_trk_run && !trk_rsp.valid) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Offset subtraction with 16-bit wrap
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            corr[a] = r_raw[a] - r_off[a];
        end
    end

    // Tracking issue: one extreme per cycle into the divide unit
    always_comb begin
        trk_v         = r_corr[r_trk[EXT_IDX_W-1:1]];
        trk_m         = r_ext[r_trk];
        trk_sum       = SUM_W'(trk_v) + (SUM_W'(trk_m) <<< 2);
        trk_req.valid = r_trk_run;
        trk_req.tag   = r_trk;
        trk_req.upd   = r_trk[0] ? (trk_v < trk_m) : (trk_v > trk_m);
    end

    chhc_div5 u_div5 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (trk_req),
        .i_sum   (trk_sum),
        .o_rsp   (trk_rsp),
        .o_quot  (trk_quot)
    );

    chhc_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cordic_start),
        .i_x       (corr[0]),
        .i_y       (corr[1]),
        .o_done    (cordic_done),
        .o_heading (cordic_heading)
    );

    // Control state, offsets and calibration flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_cal_started <= 1'b0;
            r_trk_run     <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_off[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            // Commit takes the midpoints before the sample is corrected
            if (in_fire && s_axis_tuser == REQ_COMMIT && r_cal_started) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_off[a] <= mid_tz(r_ext[2*a], r_ext[2*a+1]);
                end
                r_cal_started <= 1'b0;
            end
            if (r_state == S_CORRECT && r_req == REQ_CAL) begin
                if (!r_cal_started) begin
                    r_cal_started <= 1'b1;
                end else begin
                    r_trk_run <= 1'b1;
                end
            end else if (r_trk_run && r_trk == EXT_LAST) begin
                r_trk_run <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= s_axis_tuser;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_raw[a] <= s_axis_tdata[a*AXIS_W +: AXIS_W];
            end
        end
        if (r_state == S_CORRECT) begin
            r_trk <= '0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_corr[a] <= corr[a];
            end
            // First calibration sample seeds both extremes
            if (r_req == REQ_CAL && !r_cal_started) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_ext[2*a]   <= corr[a];
                    r_ext[2*a+1] <= corr[a];
                end
            end
        end else if (r_trk_run) begin
            r_trk <= r_trk + 1'b1;
        end
        if (trk_rsp.valid && trk_rsp.upd) begin
            r_ext[trk_rsp.tag] <= trk_quot;
        end
        if (cordic_done) begin
            r_head <= cordic_heading;
        end
        if (out_load) begin
            r_out_data <= {1'b0, r_head, r_corr[2], r_corr[1], r_corr[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ tb/sv/compass_heading_hard_iron_cal_test.sv @@
module compass_heading_hard_iron_cal_test;
    timeunit 1ns;
    timeprecision 1ps;

    import chhc_pkg::*;

    // Spare request code; the block treats it as a plain measurement
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    localparam int ITEMS_PER_PHASE = 457;
    localparam int NUM_PHASES      = 4;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 2 * (CORDIC_STEPS + 4);

    // atan(2^-i) in 2^-20 degree, rounded to nearest
    localparam longint ATAN_STEP_ANGLE [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic signed [AXIS_W-1:0] corr_x;
        logic signed [AXIS_W-1:0] corr_y;
        logic signed [AXIS_W-1:0] corr_z;
        logic [HEADING_W-1:0]     heading;
    } t_corrected_sample;

    // Tracks offsets and extremes and holds the corrected samples still owed
    class heading_checker;
        logic signed [AXIS_W-1:0] offset [NUM_AXES];
        int                       axis_max [NUM_AXES];
        int                       axis_min [NUM_AXES];
        bit                       cal_active;
        t_corrected_sample        pending_results [$];
        int                       errors;
        int                       checked;
        int                       req_count [4];

        function new();
            foreach (offset[a]) begin
                offset[a]   = '0;
                axis_max[a] = 0;
                axis_min[a] = 0;
            end
            cal_active = 1'b0;
            errors     = 0;
            checked    = 0;
            foreach (req_count[r]) req_count[r] = 0;
        endfunction

        // CORDIC vectoring heading, 1/2^HEADING_FRAC_BITS degree, 0..360
        function logic [HEADING_W-1:0] heading_of_vector(logic signed [AXIS_W-1:0] cx,
                                                         logic signed [AXIS_W-1:0] cy);
            longint x;
            longint y;
            longint dx;
            longint dy;
            longint acc;
            longint full;
            full = longint'(180) << ANG_FRAC;
            x    = longint'(cx) * (longint'(1) << PRESCALE_SH);
            y    = longint'(cy) * (longint'(1) << PRESCALE_SH);
            acc  = 0;
            // Left half plane: fold over and start from +/-180
            if (x < 0) begin
                acc = (y >= 0) ? full : -full;
                x   = -x;
                y   = -y;
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x   = x + dx;
                    y   = y - dy;
                    acc = acc + ATAN_STEP_ANGLE[i];
                end else if (y < 0) begin
                    x   = x - dx;
                    y   = y + dy;
                    acc = acc - ATAN_STEP_ANGLE[i];
                end
            end
            acc = acc + full;
            if (acc < 0) acc = 0;
            if (acc > 2 * full) acc = 2 * full;
            return HEADING_W'(acc >>> (ANG_FRAC - HEADING_FRAC_BITS));
        endfunction

        // Accepted request: update calibration state, queue the corrected sample
        function void note_request(logic [REQ_W-1:0] req, logic [IN_DATA_W-1:0] data);
            logic signed [AXIS_W-1:0] raw  [NUM_AXES];
            logic signed [AXIS_W-1:0] corr [NUM_AXES];
            int                       v;
            t_corrected_sample        res;
            req_count[req]++;
            foreach (raw[a]) raw[a] = data[a*AXIS_W +: AXIS_W];

            // Commit only takes effect with a calibration run in progress
            if (req == REQ_COMMIT && cal_active) begin
                foreach (offset[a]) offset[a] = AXIS_W'((axis_max[a] + axis_min[a]) / 2);
                cal_active = 1'b0;
            end

            foreach (corr[a]) corr[a] = raw[a] - offset[a];

            if (req == REQ_CAL) begin
                foreach (corr[a]) begin
                    v = corr[a];
                    if (!cal_active) begin
                        axis_max[a] = v;
                        axis_min[a] = v;
                    end else begin
                        if (v > axis_max[a]) axis_max[a] = (v + 4 * axis_max[a]) / 5;
                        if (v < axis_min[a]) axis_min[a] = (v + 4 * axis_min[a]) / 5;
                    end
                end
                cal_active = 1'b1;
            end

            res.corr_x  = corr[0];
            res.corr_y  = corr[1];
            res.corr_z  = corr[2];
            res.heading = heading_of_vector(corr[0], corr[1]);
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            t_corrected_sample exp_res;
            logic signed [AXIS_W-1:0] got_x;
            logic signed [AXIS_W-1:0] got_y;
            logic signed [AXIS_W-1:0] got_z;
            logic [HEADING_W-1:0]     got_heading;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata=%h", data);
                errors++;
                return;
            end
            exp_res     = pending_results.pop_front();
            got_x       = data[0 +: AXIS_W];
            got_y       = data[AXIS_W +: AXIS_W];
            got_z       = data[2*AXIS_W +: AXIS_W];
            got_heading = data[3*AXIS_W +: HEADING_W];
            checked++;
            if (got_x !== exp_res.corr_x) begin
                $error("corr_x: expected %0d, got %0d", exp_res.corr_x, got_x);
                errors++;
            end
            if (got_y !== exp_res.corr_y) begin
                $error("corr_y: expected %0d, got %0d", exp_res.corr_y, got_y);
                errors++;
            end
            if (got_z !== exp_res.corr_z) begin
                $error("corr_z: expected %0d, got %0d", exp_res.corr_z, got_z);
                errors++;
            end
            if (got_heading !== exp_res.heading) begin
                $error("heading: expected %0d, got %0d", exp_res.heading, got_heading);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // raw_x, raw_y, raw_z
    logic [REQ_W-1:0]      s_axis_tuser = '0;   // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // corr_x, corr_y, corr_z, heading, pad

    heading_checker checker_h = new();
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             quiet_cycles = 0;

    compass_heading_hard_iron_cal u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor both handshakes; watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) checker_h.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                checker_h.note_request(s_axis_tuser, s_axis_tdata);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // One request, with optional idle cycles ahead of it
    task automatic push_request(input logic [REQ_W-1:0] req,
                                input logic signed [AXIS_W-1:0] x,
                                input logic signed [AXIS_W-1:0] y,
                                input logic signed [AXIS_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic signed [AXIS_W-1:0] rand_axis();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return AXIS_W'(int'($urandom_range(400)) - 200);
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    // Calibration run around a random center, then commit, with measures around it
    task automatic run_cal_sequence(inout int sent);
        int center [NUM_AXES];
        int spread;
        int n_cal;
        logic signed [AXIS_W-1:0] v [NUM_AXES];
        spread = $urandom_range(20000, 50);
        foreach (center[a]) center[a] = int'($urandom_range(16000)) - 8000;
        n_cal = $urandom_range(16, 1);
        for (int i = 0; i < n_cal; i++) begin
            foreach (v[a]) v[a] = AXIS_W'(center[a] + int'($urandom_range(2 * spread)) - spread);
            push_request(REQ_CAL, v[0], v[1], v[2]);
        end
        sent += n_cal;
        repeat ($urandom_range(2)) begin
            push_request(REQ_MEASURE, rand_axis(), rand_axis(), rand_axis());
            sent++;
        end
        push_request(REQ_COMMIT, rand_axis(), rand_axis(), rand_axis());
        sent++;
        repeat ($urandom_range(3)) begin
            foreach (v[a]) v[a] = AXIS_W'(center[a] + int'($urandom_range(2 * spread)) - spread);
            push_request(REQ_MEASURE, v[0], v[1], v[2]);
            sent++;
        end
    endtask

    initial begin
        int phase_send [NUM_PHASES];
        int phase_stall [NUM_PHASES];
        int sent;
        phase_send  = '{0, 84, 0, 25};
        phase_stall = '{0, 0, 84, 25};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: axis extremes, quadrant edges, commit before calibration, spare code
        push_request(REQ_MEASURE, 16'sd0, 16'sd0, 16'sd0);
        push_request(REQ_MEASURE, 16'sh8000, 16'sd0, 16'sd0);
        push_request(REQ_MEASURE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_request(REQ_MEASURE, 16'sh8000, 16'sh8000, 16'sh8000);
        push_request(REQ_MEASURE, 16'sh7fff, 16'sh8000, 16'sd0);
        push_request(REQ_MEASURE, 16'sh8000, 16'sh7fff, -16'sd1);
        push_request(REQ_MEASURE, 16'sd0, 16'sd100, 16'sd3);
        push_request(REQ_MEASURE, 16'sd0, -16'sd100, 16'sd3);
        push_request(REQ_MEASURE, -16'sd1, -16'sd1, 16'sd0);
        push_request(REQ_COMMIT, 16'sd1000, -16'sd1000, 16'sd5);
        push_request(REQ_SPARE, 16'sd1234, -16'sd4321, 16'sd7);
        // First calibration sample seeds the extremes, later ones smooth them
        push_request(REQ_CAL, 16'sd500, -16'sd300, 16'sd200);
        push_request(REQ_CAL, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_request(REQ_CAL, 16'sh8000, 16'sh8000, 16'sh8000);
        push_request(REQ_CAL, 16'sd100, 16'sd100, 16'sd100);
        push_request(REQ_CAL, -16'sd1, 16'sd1, 16'sd0);
        push_request(REQ_COMMIT, 16'sd0, 16'sd0, 16'sd0);
        push_request(REQ_MEASURE, 16'sh8000, 16'sh7fff, 16'sd0);
        push_request(REQ_MEASURE, 16'sh7fff, 16'sh8000, 16'sh8000);
        // Second run starts from nonzero offsets, so corrected values wrap
        push_request(REQ_CAL, 16'sh7f00, 16'sh8100, 16'sh7fff);
        push_request(REQ_CAL, 16'sh8000, 16'sh7fff, 16'sh8000);
        push_request(REQ_COMMIT, 16'sd17, -16'sd17, 16'sd0);
        push_request(REQ_SPARE, 16'sh8000, 16'sd0, 16'sh7fff);
        push_request(REQ_COMMIT, 16'sd5, 16'sd5, 16'sd5);

        // Random phases with different idle and stall rates
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_stall[p];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 80) begin
                    run_cal_sequence(sent);
                end else begin
                    push_request(REQ_W'($urandom_range(3)), rand_axis(), rand_axis(),
                                 rand_axis());
                    sent++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (checker_h.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d measure, %0d calibration, %0d commit and %0d spare-code requests",
                 checker_h.req_count[REQ_MEASURE], checker_h.req_count[REQ_CAL],
                 checker_h.req_count[REQ_COMMIT], checker_h.req_count[REQ_SPARE]);
        $display("%0d corrected samples with heading compared, under four idle/stall mixes",
                 checker_h.checked);
        if (checker_h.errors == 0 && checker_h.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/chhc_pkg.sv
design/chhc_div5.sv
design/chhc_cordic.sv
design/compass_heading_hard_iron_cal.sv
tb/sv/compass_heading_hard_iron_cal_test.sv
